FILE: sv/dhcpoa_pkg.sv
`default_nettype none
package dhcpoa_pkg;

   // input byte stream
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // reply word stream
   typedef struct packed {
      logic [63:0] reply_word;
      logic [3:0]  word_bytes;
      logic        word_last;
   } rsp_type;

   // configured addresses and lease
   typedef struct packed {
      logic [31:0] server_address;
      logic [31:0] client_address;
      logic [31:0] subnet_mask;
      logic [31:0] lease_seconds;
   } cfg_type;

   // one reply to be sent, handed from parser to emitter
   typedef struct packed {
      logic [31:0] xid;
      logic [15:0] flags;
      logic [63:0] hw_hi;
      logic [63:0] hw_lo;
      logic        discover;
   } job_type;

   // queue status between queue and emitter
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // register indexes
   localparam logic [1:0] CSR_SERVER_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_CLIENT_ADDRESS = 2'd1;
   localparam logic [1:0] CSR_SUBNET_MASK    = 2'd2;
   localparam logic [1:0] CSR_LEASE_SECONDS  = 2'd3;

   localparam logic [31:0] RESET_SERVER_ADDRESS = 32'hC0A8_0701;
   localparam logic [31:0] RESET_CLIENT_ADDRESS = 32'hC0A8_0702;
   localparam logic [31:0] RESET_SUBNET_MASK    = 32'hFFFF_FF00;
   localparam logic [31:0] RESET_LEASE_SECONDS  = 32'd86400;

   // byte positions
   localparam logic [9:0] CAPTURE_LIMIT  = 10'd548;
   localparam logic [9:0] POS_MAX        = 10'd1023;
   localparam logic [9:0] POS_OPTIONS    = 10'd240;
   localparam logic [9:0] POS_MIN_LAST   = 10'd239;
   localparam logic [9:0] POS_XID_FIRST  = 10'd4;
   localparam logic [9:0] POS_XID_LAST   = 10'd7;
   localparam logic [9:0] POS_FLAGS_HI   = 10'd10;
   localparam logic [9:0] POS_FLAGS_LO   = 10'd11;
   localparam logic [9:0] POS_HW_FIRST   = 10'd28;
   localparam logic [9:0] POS_HW_MID     = 10'd35;
   localparam logic [9:0] POS_HW_LAST    = 10'd43;

   // option walk states
   localparam logic [1:0] PH_CODE   = 2'd0;
   localparam logic [1:0] PH_LENGTH = 2'd1;
   localparam logic [1:0] PH_SKIP   = 2'd2;
   localparam logic [1:0] PH_TYPE   = 2'd3;

   // option and message codes
   localparam logic [7:0] OPT_PAD        = 8'h00;
   localparam logic [7:0] OPT_END        = 8'hFF;
   localparam logic [7:0] OPT_MSG_TYPE   = 8'd53;
   localparam logic [7:0] OPT_SERVER_ID  = 8'd54;
   localparam logic [7:0] OPT_SUBNET     = 8'd1;
   localparam logic [7:0] OPT_ROUTER     = 8'd3;
   localparam logic [7:0] OPT_LEASE      = 8'd51;
   localparam logic [7:0] MSG_DISCOVER   = 8'd1;
   localparam logic [7:0] MSG_OFFER      = 8'd2;
   localparam logic [7:0] MSG_REQUEST    = 8'd3;
   localparam logic [7:0] MSG_ACK        = 8'd5;
   localparam logic [7:0] BOOT_REPLY     = 8'd2;
   localparam logic [7:0] HTYPE_ETHER    = 8'd1;
   localparam logic [7:0] HLEN_ETHER     = 8'd6;
   localparam logic [7:0] LEN_ADDR       = 8'd4;
   localparam logic [7:0] LEN_TYPE       = 8'd1;
   localparam logic [31:0] MAGIC_COOKIE  = 32'h6382_5363;

   // reply word framing
   localparam logic [5:0] LAST_WORD   = 6'd33;
   localparam logic [3:0] BYTES_FULL  = 4'd8;
   localparam logic [3:0] BYTES_TAIL  = 4'd4;

   localparam int QUEUE_DEPTH = 2;

endpackage
`default_nettype wire

FILE: sv/dhcpoa_parser.sv
`default_nettype none
module dhcpoa_parser
   import dhcpoa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    take,
   input  wire req_type req_data,
   output logic         push,
   output job_type      push_job
);

   logic [9:0]  pos_ff, pos_in;
   logic [31:0] xid_ff, xid_in;
   logic [15:0] flags_ff, flags_in;
   logic [63:0] hw_hi_ff, hw_hi_in;
   logic [63:0] hw_lo_ff, hw_lo_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  skip_ff, skip_in;
   logic        pending_ff, pending_in;
   logic [7:0]  mtype_ff, mtype_in;
   logic        done_ff, done_in;
   logic [7:0]  b;
   logic        walk;

   assign b    = req_data.data_byte;
   assign walk = (pos_ff >= POS_OPTIONS) && (pos_ff < CAPTURE_LIMIT) && !done_ff;

   always_comb begin
      pos_in     = pos_ff;
      xid_in     = xid_ff;
      flags_in   = flags_ff;
      hw_hi_in   = hw_hi_ff;
      hw_lo_in   = hw_lo_ff;
      phase_in   = phase_ff;
      skip_in    = skip_ff;
      pending_in = pending_ff;
      mtype_in   = mtype_ff;
      done_in    = done_ff;

      // header field capture
      if (pos_ff >= POS_XID_FIRST && pos_ff <= POS_XID_LAST) begin
         xid_in = {xid_ff[23:0], b};
      end else if (pos_ff == POS_FLAGS_HI || pos_ff == POS_FLAGS_LO) begin
         flags_in = {flags_ff[7:0], b};
      end else if (pos_ff >= POS_HW_FIRST && pos_ff <= POS_HW_MID) begin
         hw_hi_in = {hw_hi_ff[55:0], b};
      end else if (pos_ff > POS_HW_MID && pos_ff <= POS_HW_LAST) begin
         hw_lo_in = {hw_lo_ff[55:0], b};
      end

      // option walk
      if (walk) begin
         case (phase_ff)
            PH_CODE: begin
               if (b == OPT_END) begin
                  done_in = 1'b1;
               end else if (b != OPT_PAD) begin
                  pending_in = (b == OPT_MSG_TYPE);
                  phase_in   = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               if (pending_ff && b != 8'd0) begin
                  phase_in = PH_TYPE;
               end else if (b == 8'd0) begin
                  phase_in = PH_CODE;
               end else begin
                  skip_in  = b;
                  phase_in = PH_SKIP;
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 8'd1;
               if (skip_ff == 8'd1) begin
                  phase_in = PH_CODE;
               end
            end
            PH_TYPE: begin
               mtype_in = b;
               done_in  = 1'b1;
            end
            default: begin
               phase_in = PH_CODE;
            end
         endcase
      end

      if (pos_ff != POS_MAX) begin
         pos_in = pos_ff + 10'd1;
      end
   end

   // reply wanted when a discover or request closes a datagram of at least 240 bytes
   assign push = take && req_data.last_byte && (pos_ff >= POS_MIN_LAST)
                 && (mtype_in == MSG_DISCOVER || mtype_in == MSG_REQUEST);

   assign push_job = '{xid: xid_in, flags: flags_in, hw_hi: hw_hi_in, hw_lo: hw_lo_in,
                       discover: (mtype_in == MSG_DISCOVER)};

   always_ff @(posedge clock) begin
      if (reset || (take && req_data.last_byte)) begin
         pos_ff     <= '0;
         xid_ff     <= '0;
         flags_ff   <= '0;
         hw_hi_ff   <= '0;
         hw_lo_ff   <= '0;
         phase_ff   <= PH_CODE;
         skip_ff    <= '0;
         pending_ff <= 1'b0;
         mtype_ff   <= '0;
         done_ff    <= 1'b0;
      end else if (take) begin
         pos_ff     <= pos_in;
         xid_ff     <= xid_in;
         flags_ff   <= flags_in;
         hw_hi_ff   <= hw_hi_in;
         hw_lo_ff   <= hw_lo_in;
         phase_ff   <= phase_in;
         skip_ff    <= skip_in;
         pending_ff <= pending_in;
         mtype_ff   <= mtype_in;
         done_ff    <= done_in;
      end
   end

   // skipping always has bytes left to skip
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) |-> (skip_ff != 8'd0))
      else $error("skip phase with zero count");

   // the type value is only awaited after option 53
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TYPE) |-> pending_ff)
      else $error("type phase without option 53");

   // walk never starts before the options area
   assert property (@(posedge clock) disable iff (reset)
      (pos_ff < POS_OPTIONS) |-> (phase_ff == PH_CODE && !done_ff && mtype_ff == 8'd0))
      else $error("option walk state before options");

endmodule
`default_nettype wire

FILE: sv/dhcpoa_queue.sv
`default_nettype none
module dhcpoa_queue
   import dhcpoa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire job_type     push_job,
   input  wire logic        pop,
   output job_type          head,
   output queue_status_type status
);

   job_type    slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'(QUEUE_DEPTH));
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH))
      else $error("queue overfilled");

   assert property (@(posedge clock) disable iff (reset)
      !(push && status.full) && !(pop && status.empty))
      else $error("queue push when full or pop when empty");

   assert property (@(posedge clock) disable iff (reset)
      ((wr_ptr_ff == rd_ptr_ff) == (count_ff == 2'd0 || count_ff == 2'(QUEUE_DEPTH))))
      else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

FILE: sv/dhcpoa_emitter.sv
`default_nettype none
module dhcpoa_emitter
   import dhcpoa_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire job_type          head,
   input  wire queue_status_type status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data
);

   job_type     job_ff, job_in;
   logic        busy_ff, busy_in;
   logic [5:0]  idx_ff, idx_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic        load;
   logic [63:0] word;
   logic [7:0]  reply_type;

   assign load       = !out_valid_ff || !rsp_stall;
   assign pop        = !busy_ff && !status.empty;
   assign reply_type = job_ff.discover ? MSG_OFFER : MSG_ACK;

   // reply word by index, unlisted words are all zero
   always_comb begin
      case (idx_ff)
         6'd0:  word = {BOOT_REPLY, HTYPE_ETHER, HLEN_ETHER, 8'h00, job_ff.xid};
         6'd1:  word = {16'h0000, job_ff.flags, 32'h0000_0000};
         6'd2:  word = {cfg.client_address, cfg.server_address};
         6'd3:  word = {32'h0000_0000, job_ff.hw_hi[63:32]};
         6'd4:  word = {job_ff.hw_hi[31:0], job_ff.hw_lo[63:32]};
         6'd5:  word = {job_ff.hw_lo[31:0], 32'h0000_0000};
         6'd29: word = {32'h0000_0000, MAGIC_COOKIE};
         6'd30: word = {OPT_MSG_TYPE, LEN_TYPE, reply_type, OPT_SERVER_ID, LEN_ADDR,
                        cfg.server_address[31:8]};
         6'd31: word = {cfg.server_address[7:0], OPT_SUBNET, LEN_ADDR, cfg.subnet_mask,
                        OPT_ROUTER};
         6'd32: word = {LEN_ADDR, cfg.server_address, OPT_LEASE, LEN_ADDR,
                        cfg.lease_seconds[31:24]};
         6'd33: word = {cfg.lease_seconds[23:0], OPT_END, 32'h0000_0000};
         default: word = 64'h0;
      endcase
   end

   always_comb begin
      job_in       = job_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (pop) begin
         job_in  = head;
         busy_in = 1'b1;
         idx_in  = '0;
      end
      if (load) begin
         out_valid_in = busy_ff;
         if (busy_ff) begin
            out_in.reply_word = word;
            out_in.word_bytes = (idx_ff == LAST_WORD) ? BYTES_TAIL : BYTES_FULL;
            out_in.word_last  = (idx_ff == LAST_WORD);
            idx_in            = idx_ff + 6'd1;
            if (idx_ff == LAST_WORD) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= LAST_WORD))
      else $error("word index past end of reply");

   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && load && idx_ff == LAST_WORD) |=> (out_valid_ff && out_ff.word_last && !busy_ff))
      else $error("final word not presented at end of reply");

   assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> (idx_ff == 6'd0))
      else $error("reply started mid-sequence");

endmodule
`default_nettype wire

FILE: sv/dhcp_offer_ack_responder.sv
`default_nettype none
// channel   direction  payload                               transfer when
// req       in         data_byte[7:0], last_byte             req_valid & !req_stall
// rsp       out        reply_word[63:0], word_bytes, word_last  rsp_valid & !rsp_stall
// csr       in         index[1:0], wdata[31:0]               csr_wr_en
//
// one byte per cycle in unless req_stall; parsing keeps pace with the byte stream
// a reply is 34 words, one per cycle unless stalled, from the emitter output register
// a gap between replies while the emitter loads the next job from the queue
// reset is synchronous: parse state and queue clear, registers return to defaults
// req_stall rises only while the two-entry reply queue is full
module dhcp_offer_ack_responder
   import dhcpoa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   logic             take;
   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          head;
   queue_status_type status;

   // hold off the byte stream while no room for another reply
   assign req_stall = status.full;
   assign take      = req_valid && !req_stall;

   // configuration register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SERVER_ADDRESS: cfg_in.server_address = csr_wdata;
            CSR_CLIENT_ADDRESS: cfg_in.client_address = csr_wdata;
            CSR_SUBNET_MASK:    cfg_in.subnet_mask    = csr_wdata;
            CSR_LEASE_SECONDS:  cfg_in.lease_seconds  = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{server_address: RESET_SERVER_ADDRESS,
                     client_address: RESET_CLIENT_ADDRESS,
                     subnet_mask:    RESET_SUBNET_MASK,
                     lease_seconds:  RESET_LEASE_SECONDS};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: byte parser and option walk
   dhcpoa_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req_data (req_data),
      .push     (push),
      .push_job (push_job)
   );

   // pending replies between front and back
   dhcpoa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (status)
   );

   // back: reply word generator with output register
   dhcpoa_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .status    (status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
